### design/qoienc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// QOI RGB stream encoder package
// Shared types, opcode constants and helper functions for the QOI encoder.
// ----------------------------------------------------------------------------
package qoienc_pkg;

  // Widths of the pixel and of the configuration data, depth of the color hash table.
  localparam int PIXEL_W     = 24;
  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // Chunk opcodes.
  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hc0;
  localparam logic [7:0] OP_RGB   = 8'hfe;

  // Longest run a single run chunk can carry.
  localparam logic [5:0] RUN_MAX = 6'd62;

  // Hash bias: alpha is always 255, weighted by 11.
  localparam int HASH_BIAS = 255 * 11;

  // Header and end marker constants.
  localparam logic [7:0] MAGIC_0    = 8'h71; // q
  localparam logic [7:0] MAGIC_1    = 8'h6f; // o
  localparam logic [7:0] MAGIC_2    = 8'h69; // i
  localparam logic [7:0] MAGIC_3    = 8'h66; // f
  localparam logic [7:0] CHANNELS   = 8'd3;
  localparam logic [7:0] COLORSPACE = 8'd0;
  localparam logic [7:0] EOI_FILL   = 8'h00;
  localparam logic [7:0] EOI_TAIL   = 8'h01;
  localparam int         HDR_BYTES  = 14;
  localparam int         EOI_BYTES  = 8;

  // Output sequencer phases.
  localparam logic [1:0] PH_HDR  = 2'd0;
  localparam logic [1:0] PH_PRE  = 2'd1;
  localparam logic [1:0] PH_CODE = 2'd2;
  localparam logic [1:0] PH_EOI  = 2'd3;

  // One input pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       first_pixel;
    logic       last_pixel;
  } pixel_t;

  // One output byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } code_t;

  // Byte list produced by one pixel, walked by the output sequencer.
  typedef struct packed {
    logic            hdr;
    logic            pre;
    logic [7:0]      pre_byte;
    logic [3:0][7:0] code;
    logic [2:0]      code_cnt;
    logic            eoi;
  } job_t;

  // Index hash of a pixel: (3r + 5g + 7b + 11*255) mod 64.
  function automatic logic [SLOT_W-1:0] qoi_hash(input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
    logic [11:0] s;
    s = 12'(r) * 12'd3 + 12'(g) * 12'd5 + 12'(b) * 12'd7 + 12'(HASH_BIAS);
    return s[SLOT_W-1:0];
  endfunction

  // Header byte at a given position; width and height are 32-bit big endian.
  function automatic logic [7:0] qoi_header_byte(input logic [3:0]       pos,
                                                 input logic [CFG_W-1:0] w,
                                                 input logic [CFG_W-1:0] h);
    logic [7:0] v;
    unique case (pos)
      4'd0:    v = MAGIC_0;
      4'd1:    v = MAGIC_1;
      4'd2:    v = MAGIC_2;
      4'd3:    v = MAGIC_3;
      4'd6:    v = w[15:8];
      4'd7:    v = w[7:0];
      4'd10:   v = h[15:8];
      4'd11:   v = h[7:0];
      4'd12:   v = CHANNELS;
      4'd13:   v = COLORSPACE;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### design/qoi_rgb_stream_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// QOI RGB stream encoder
// Codes a stream of RGB pixels into QOI chunks, one output byte per transfer.
// ----------------------------------------------------------------------------
// A pixel is accepted on a transfer; its hash slot addresses the 64-entry color
// index RAM at once, and in the next cycle the read data, the previous pixel
// and the run count decide the chunk; once the sequencer can take it, the
// state is updated and the pixel's byte list handed to the output sequencer.
// The sequencer drives one byte per cycle into the output register unless
// code_ready stalls it, so the block sustains one pixel per cycle while each
// pixel makes at most one byte (runs, INDEX and DIFF chunks); a pixel that
// makes more holds the input until its bytes are out: 2 bytes for LUMA, 4 for a
// literal, 14 for the header, 8 for the end marker and one for a flushed run.
// image_width and image_height are read while the header goes out and must
// be written only while the block idles; the block does not enforce this.
// The configuration port always accepts; indexes beyond height are ignored.
// ----------------------------------------------------------------------------
module qoi_rgb_stream_encoder
  import qoienc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pixel_valid,
  output logic                      pixel_ready,
  input  wire pixel_t               pixel,
  output logic                      code_valid,
  input  wire logic                 code_ready,
  output code_t                     code,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1);
      image_height <= CFG_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == CFG_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  // Coding stage registers and state.
  logic                s1_valid;
  pixel_t              s1_pix;
  logic [SLOT_W-1:0]   s1_slot;
  logic [PIXEL_W-1:0]  prev_pixel;
  logic [5:0]          run_count;
  logic [TABLE_DEPTH-1:0] index_valid;
  logic                fwd_valid;
  logic [SLOT_W-1:0]   fwd_slot;
  logic [PIXEL_W-1:0]  fwd_data;
  logic [PIXEL_W-1:0]  ram_rd_data;

  // Output sequencer registers.
  logic       job_valid;
  job_t       job;
  logic [1:0] job_phase;
  logic [3:0] job_cnt;
  code_t      out_q;
  logic       out_valid;

  // Handshake between the stages.
  logic pixel_xfer;
  logic s1_adv;
  logic job_fire;
  logic job_done;
  logic job_free;
  logic s1_zero;

  assign pixel_xfer  = pixel_valid && pixel_ready;
  assign job_fire    = job_valid && (!out_valid || code_ready);
  assign job_free    = !job_valid || (job_fire && job_done);
  assign s1_adv      = s1_valid && (s1_zero || job_free);
  assign pixel_ready = !s1_valid || s1_adv;
  assign code_valid  = out_valid;
  assign code        = out_q;

  // Color index table: read on transfer, written when a missed pixel is coded.
  logic ram_wr_en;

  qoienc_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(TABLE_DEPTH)
  ) u_index_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(s1_slot),
    .wr_data({s1_pix.red, s1_pix.green, s1_pix.blue}),
    .rd_en  (pixel_xfer),
    .rd_addr(qoi_hash(pixel.red, pixel.green, pixel.blue)),
    .rd_data(ram_rd_data)
  );

  // Chunk decision for the pixel in the coding stage.
  logic [PIXEL_W-1:0] px;
  logic [PIXEL_W-1:0] entry;
  logic [5:0]         run_in;
  logic [5:0]         run_inc;
  logic [5:0]         run_next;
  logic               same;
  logic               hit;
  logic [7:0]         dr;
  logic [7:0]         dg;
  logic [7:0]         db;
  logic [7:0]         dgr;
  logic [7:0]         dgb;
  logic [7:0]         dr_b;
  logic [7:0]         dg_b;
  logic [7:0]         db_b;
  logic [7:0]         dg_l;
  logic [7:0]         dgr_l;
  logic [7:0]         dgb_l;
  job_t               job_new;
  logic [1:0]         start_phase;

  always_comb begin
    px      = {s1_pix.red, s1_pix.green, s1_pix.blue};
    entry   = (fwd_valid && fwd_slot == s1_slot) ? fwd_data : ram_rd_data;
    run_in  = s1_pix.first_pixel ? 6'd0 : run_count;
    run_inc = run_in + 6'd1;
    same    = (px == prev_pixel);
    hit     = !same && index_valid[s1_slot] && (entry == px);

    // Channel differences wrap modulo 256.
    dr    = s1_pix.red   - prev_pixel[23:16];
    dg    = s1_pix.green - prev_pixel[15:8];
    db    = s1_pix.blue  - prev_pixel[7:0];
    dgr   = dr - dg;
    dgb   = db - dg;
    dr_b  = dr + 8'd2;
    dg_b  = dg + 8'd2;
    db_b  = db + 8'd2;
    dg_l  = dg + 8'd32;
    dgr_l = dgr + 8'd8;
    dgb_l = dgb + 8'd8;

    job_new          = '0;
    job_new.hdr      = s1_pix.first_pixel;
    job_new.eoi      = s1_pix.last_pixel;
    job_new.pre_byte = OP_RUN | {2'b00, run_in - 6'd1};
    run_next         = 6'd0;
    ram_wr_en        = 1'b0;

    if (same) begin
      // Run continues; flush it when full or at the end of the image.
      if (run_inc == RUN_MAX || s1_pix.last_pixel) begin
        job_new.code[0]  = OP_RUN | {2'b00, run_in};
        job_new.code_cnt = 3'd1;
      end else begin
        run_next = run_inc;
      end
    end else begin
      job_new.pre = (run_in != 6'd0);
      ram_wr_en   = s1_adv && !hit;
      if (hit) begin
        job_new.code[0]  = OP_INDEX | {2'b00, s1_slot};
        job_new.code_cnt = 3'd1;
      end else if (dr_b < 8'd4 && dg_b < 8'd4 && db_b < 8'd4) begin
        job_new.code[0]  = OP_DIFF | {2'b00, dr_b[1:0], dg_b[1:0], db_b[1:0]};
        job_new.code_cnt = 3'd1;
      end else if (dgr_l < 8'd16 && dg_l < 8'd64 && dgb_l < 8'd16) begin
        job_new.code[0]  = OP_LUMA | {2'b00, dg_l[5:0]};
        job_new.code[1]  = {dgr_l[3:0], dgb_l[3:0]};
        job_new.code_cnt = 3'd2;
      end else begin
        job_new.code[0]  = OP_RGB;
        job_new.code[1]  = s1_pix.red;
        job_new.code[2]  = s1_pix.green;
        job_new.code[3]  = s1_pix.blue;
        job_new.code_cnt = 3'd4;
      end
    end

    s1_zero = !(job_new.hdr || job_new.pre || job_new.code_cnt != 3'd0 || job_new.eoi);

    // First phase of the byte list that has any bytes.
    priority if (job_new.hdr) begin
      start_phase = PH_HDR;
    end else if (job_new.pre) begin
      start_phase = PH_PRE;
    end else if (job_new.code_cnt != 3'd0) begin
      start_phase = PH_CODE;
    end else begin
      start_phase = PH_EOI;
    end
  end

  // Coding stage, state and index valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      prev_pixel  <= '0;
      run_count   <= '0;
      index_valid <= '0;
      fwd_valid   <= 1'b0;
    end else begin
      if (pixel_ready) begin
        s1_valid <= pixel_valid;
      end
      if (s1_adv) begin
        prev_pixel <= px;
        run_count  <= run_next;
      end
      if (ram_wr_en) begin
        index_valid[s1_slot] <= 1'b1;
        fwd_valid            <= 1'b1;
      end
    end
  end

  // Pixel payload and forwarding copy of the last table write.
  always_ff @(posedge clk) begin
    if (pixel_xfer) begin
      s1_pix  <= pixel;
      s1_slot <= qoi_hash(pixel.red, pixel.green, pixel.blue);
    end
    if (ram_wr_en) begin
      fwd_slot <= s1_slot;
      fwd_data <= px;
    end
  end

  // Output sequencer: current byte, end of phase and next phase.
  logic [3:0] has;
  logic       phase_end;
  logic       found;
  logic [1:0] phase_nxt;
  logic [7:0] cur_byte;

  always_comb begin
    has = {job.eoi, job.code_cnt != 3'd0, job.pre, job.hdr};
    unique case (job_phase)
      PH_HDR: begin
        phase_end = (job_cnt == 4'(HDR_BYTES - 1));
        cur_byte  = qoi_header_byte(job_cnt, image_width, image_height);
      end
      PH_PRE: begin
        phase_end = 1'b1;
        cur_byte  = job.pre_byte;
      end
      PH_CODE: begin
        phase_end = (job_cnt == {1'b0, job.code_cnt - 3'd1});
        cur_byte  = job.code[job_cnt[1:0]];
      end
      default: begin
        phase_end = (job_cnt == 4'(EOI_BYTES - 1));
        cur_byte  = phase_end ? EOI_TAIL : EOI_FILL;
      end
    endcase

    found     = 1'b0;
    phase_nxt = job_phase;
    for (int q = 3; q >= 0; q--) begin
      if (2'(q) > job_phase && has[q]) begin
        found     = 1'b1;
        phase_nxt = 2'(q);
      end
    end
    job_done = phase_end && !found;
  end

  // Sequencer and output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_fire) begin
        out_valid <= 1'b1;
      end else if (code_ready) begin
        out_valid <= 1'b0;
      end
      if (job_free) begin
        job_valid <= s1_adv && !s1_zero;
      end
    end
  end

  // Sequencer and output register payload. A new byte list replaces the
  // current one only after its last byte has gone out.
  always_ff @(posedge clk) begin
    if (job_fire) begin
      out_q.out_byte  <= cur_byte;
      out_q.last_byte <= job_done;
    end
    if (job_free && s1_adv && !s1_zero) begin
      job       <= job_new;
      job_phase <= start_phase;
      job_cnt   <= 4'd0;
    end else if (job_fire) begin
      if (phase_end) begin
        job_phase <= phase_nxt;
        job_cnt   <= 4'd0;
      end else begin
        job_cnt <= job_cnt + 4'd1;
      end
    end
  end

endmodule
`default_nettype wire

### design/qoienc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module qoienc_ram
  import qoienc_pkg::*;
#(
  parameter int WIDTH = PIXEL_W,
  parameter int DEPTH = TABLE_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; a read of the same address in the same cycle returns old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
